// ===== rtl/mcg_pkg.sv =====
package mcg_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BEAT_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd7;

	// Q1.15 unity
	localparam logic [15:0] FULL_SCALE = 16'd32768;

	// Envelope divider: 32-bit numerator, 16-bit divisor, quotient never above 32768
	localparam int unsigned NUM_W     = 32;
	localparam int unsigned DEN_W     = 16;
	localparam int unsigned QUO_W     = 16;
	localparam int unsigned DIV_STEPS = QUO_W;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		SEG_ATT,
		SEG_DEC,
		SEG_SUS,
		SEG_REL
	} seg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	// Sine of a 32-bit phase, scaled to 32767: quarter-wave fold plus
	// Taylor series to the 11th power in Q30. Evaluated at elaboration only.
	function automatic logic signed [15:0] sine_of_phase(input logic [31:0] ph);
		logic [1:0]         quad;
		logic [63:0]        r;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        mag;
		logic signed [63:0] s;
		logic signed [15:0] val;
		quad = ph[31:30];
		r = {34'd0, ph[29:0]};
		if (quad[0])
			r = (64'd1 << 30) - r;
		x = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		s = signed'(x);
		term = ((term * x2) >> 30) / 64'd6;
		s = s - signed'(term);
		term = ((term * x2) >> 30) / 64'd20;
		s = s + signed'(term);
		term = ((term * x2) >> 30) / 64'd42;
		s = s - signed'(term);
		term = ((term * x2) >> 30) / 64'd72;
		s = s + signed'(term);
		term = ((term * x2) >> 30) / 64'd110;
		s = s - signed'(term);
		if (s < 0)
			s = 0;
		mag = ((unsigned'(s) * 64'd32767) + (64'd1 << 29)) >> 30;
		if (mag > 64'd32767)
			mag = 64'd32767;
		val = signed'(mag[15:0]);
		return quad[1] ? -val : val;
	endfunction

endpackage

// ===== rtl/mcg_div.sv =====
// Restoring divider, one quotient bit per cycle.
// The caller guarantees num < den * 2^QUO_W, so the quotient fits QUO_W bits.
module mcg_div import mcg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(DIV_STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// Shift in the next numerator bit and try a subtract
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient; the low numerator bits ride in the quotient register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[NUM_W-1 -: DEN_W];
			quo_q <= req.num[QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== rtl/mcg_wave_rom.sv =====
// Sine table, TABLE_SIZE entries (power of two), registered read.
module mcg_wave_rom import mcg_pkg::*; #(
	parameter int unsigned TABLE_SIZE = 2048
) (
	input  logic                          clk,
	input  logic [$clog2(TABLE_SIZE)-1:0] addr,
	output logic signed [15:0]            data
);

	localparam int unsigned IDX_W = $clog2(TABLE_SIZE);

	logic signed [15:0] rom [TABLE_SIZE];

	// Entry i holds the sine at phase i * 2^32 / TABLE_SIZE
	for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_rom
		localparam logic [63:0] PHASE = 64'(i) << (32 - IDX_W);
		assign rom[i] = sine_of_phase(PHASE[31:0]);
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end

endmodule

// ===== rtl/metronome_click_generator.sv =====
// Metronome click generator.
// Each transfer on the s_ group is one audio sample tick. s_tuser[0] asks to
// load s_tdata as the beat position before the tick is rendered. One result
// per tick leaves on the m_ group: m_tdata is the signed 16-bit sample and
// m_tuser[0] is high while the click (note plus release) is sounding.
// Registers are written through cfg_we / cfg_addr / cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// A tick inside the click goes through the 16-step envelope divider; the
// sustain part of the note skips the divider and a silent tick goes to S_OUT.
// All products go through one shared 33x18 multiplier, one per cycle.
// s_tready is high only while the sequencer is idle, so the next tick can be
// taken at the earliest in the cycle after the previous result is registered.
// The result waits in an output register: a stalled receiver holds m_tvalid
// and m_tdata, and the sequencer then waits in S_OUT and takes no next tick.
// Reset (arst_n low) restores the default registers, clears the beat position
// to zero and drops any pending result. The sine table is a constant ROM and
// needs no clearing after reset.
module metronome_click_generator import mcg_pkg::*; #(
	parameter int unsigned TABLE_SIZE = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // [23:0] start_position
	input  logic [0:0]            s_tuser,   // [0] load_position
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [15:0] sample
	output logic [0:0]            m_tuser    // [0] sounding
);

	localparam int unsigned IDX_W = $clog2(TABLE_SIZE);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_WRAP = 11'b000_0000_0010,
		S_PH0  = 11'b000_0000_0100,
		S_PH1  = 11'b000_0000_1000,
		S_NUM  = 11'b000_0001_0000,
		S_DIV  = 11'b000_0010_0000,
		S_ENV  = 11'b000_0100_0000,
		S_EG   = 11'b000_1000_0000,
		S_EW   = 11'b001_0000_0000,
		S_RND  = 11'b010_0000_0000,
		S_OUT  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [23:0] beat_period_q;
	logic [15:0] attack_len_q;
	logic [15:0] decay_len_q;
	logic [15:0] sustain_level_q;
	logic [15:0] hold_len_q;
	logic [15:0] release_len_q;
	logic [31:0] phase_step_q;
	logic [15:0] gain_q;

	logic [23:0] pos_q;
	logic        out_valid_q;
	logic [15:0] out_sample_q;
	logic        out_snd_q;

	// Per-tick working registers
	logic [23:0]        t_q;
	logic [31:0]        ph_q;
	logic               win_q;
	seg_t               seg_q;
	logic [15:0]        e_q;
	logic signed [50:0] prod_q;
	logic [15:0]        res_sample_q;
	logic               res_snd_q;

	logic [23:0]        period;
	logic [15:0]        sus;
	logic [16:0]        win_lim;
	logic [16:0]        att_dec;
	logic [24:0]        t_inc;
	logic [16:0]        rel_d;
	logic [15:0]        dec_lvl;
	logic               out_load;

	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [50:0] mul_p;

	logic signed [15:0] wave;
	logic signed [51:0] rnd;
	logic signed [21:0] shv;
	logic [15:0]        sat;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Derived limits
	assign period  = (beat_period_q == '0) ? 24'd1 : beat_period_q;
	assign sus     = (sustain_level_q > FULL_SCALE) ? FULL_SCALE : sustain_level_q;
	assign win_lim = {1'b0, hold_len_q} + {1'b0, release_len_q};
	assign att_dec = {1'b0, attack_len_q} + {1'b0, decay_len_q};
	assign t_inc   = {1'b0, t_q} + 25'd1;
	assign rel_d   = t_q[16:0] - {1'b0, hold_len_q};

	assign s_tready = (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_tready);

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_PH0: begin
				mul_a = {1'b0, phase_step_q};
				mul_b = {2'b0, t_q[15:0]};
			end
			S_PH1: begin
				mul_a = {1'b0, phase_step_q};
				mul_b = {10'b0, t_q[23:16]};
			end
			S_NUM: begin
				case (seg_q)
					SEG_ATT: begin
						mul_a = {17'b0, t_q[15:0]};
						mul_b = {2'b0, FULL_SCALE};
					end
					SEG_DEC: begin
						mul_a = {17'b0, t_q[15:0] - attack_len_q};
						mul_b = {2'b0, FULL_SCALE - sus};
					end
					SEG_REL: begin
						mul_a = {17'b0, release_len_q - rel_d[15:0]};
						mul_b = {2'b0, sus};
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			S_EG: begin
				mul_a = {17'b0, gain_q};
				mul_b = {2'b0, e_q};
			end
			S_EW: begin
				mul_a = {1'b0, prod_q[31:0]};
				mul_b = {{2{wave[15]}}, wave};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Divider request: numerator straight from the multiplier
	always_comb begin
		div_req.start = (state_q == S_NUM) && win_q && (seg_q != SEG_SUS);
		div_req.num   = mul_p[31:0];
		case (seg_q)
			SEG_ATT: div_req.den = attack_len_q;
			SEG_DEC: div_req.den = decay_len_q;
			default: div_req.den = release_len_q;
		endcase
	end

	mcg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mcg_wave_rom #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_rom (
		.clk  (clk),
		.addr (ph_q[31 -: IDX_W]),
		.data (wave)
	);

	// Decay level before the sustain floor
	assign dec_lvl = (div_rsp.quo >= FULL_SCALE) ? 16'd0 : FULL_SCALE - div_rsp.quo;

	// Round to nearest, then saturate to 16 bits
	assign rnd = {prod_q[50], prod_q} + 52'sd536870912;
	assign shv = rnd[51:30];
	always_comb begin
		if (shv > 22'sd32767)
			sat = 16'h7FFF;
		else if (shv < -22'sd32768)
			sat = 16'h8000;
		else
			sat = shv[15:0];
	end

	// Sequencer, beat position, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			pos_q           <= '0;
			out_valid_q     <= 1'b0;
			beat_period_q   <= 24'd24000;
			attack_len_q    <= 16'd480;
			decay_len_q     <= 16'd960;
			sustain_level_q <= 16'd6554;
			hold_len_q      <= 16'd2400;
			release_len_q   <= 16'd960;
			phase_step_q    <= 32'd89478485;
			gain_q          <= 16'd32768;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_BEAT_PERIOD:   beat_period_q   <= cfg_data[23:0];
					REG_ATTACK_LEN:    attack_len_q    <= cfg_data[15:0];
					REG_DECAY_LEN:     decay_len_q     <= cfg_data[15:0];
					REG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data[15:0];
					REG_HOLD_LEN:      hold_len_q      <= cfg_data[15:0];
					REG_RELEASE_LEN:   release_len_q   <= cfg_data[15:0];
					REG_PHASE_STEP:    phase_step_q    <= cfg_data[31:0];
					REG_GAIN:          gain_q          <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_WRAP;
				S_WRAP: state_q <= S_PH0;
				S_PH0: begin
					// advance the beat position once the tick position is settled
					pos_q   <= (t_inc >= {1'b0, period}) ? 24'd0 : t_inc[23:0];
					state_q <= S_PH1;
				end
				S_PH1: state_q <= S_NUM;
				S_NUM: begin
					if (!win_q)
						state_q <= S_OUT;
					else if (seg_q == SEG_SUS)
						state_q <= S_EG;
					else
						state_q <= S_DIV;
				end
				S_DIV: if (div_rsp.done) state_q <= S_ENV;
				S_ENV: state_q <= S_EG;
				S_EG:  state_q <= S_EW;
				S_EW:  state_q <= S_RND;
				S_RND: state_q <= S_OUT;
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (s_tvalid) t_q <= s_tuser[0] ? s_tdata : pos_q;
			S_WRAP: if (t_q >= period) t_q <= '0;
			S_PH0: begin
				prod_q <= mul_p;
				win_q  <= (t_q < {7'b0, win_lim});
			end
			S_PH1: begin
				// phase = t * phase_step mod 2^32, high byte of t added here
				ph_q <= prod_q[31:0] + {mul_p[15:0], 16'b0};
				if (t_q >= {8'b0, hold_len_q})
					seg_q <= SEG_REL;
				else if (t_q < {8'b0, attack_len_q})
					seg_q <= SEG_ATT;
				else if (t_q < {7'b0, att_dec})
					seg_q <= SEG_DEC;
				else
					seg_q <= SEG_SUS;
			end
			S_NUM: begin
				if (!win_q) begin
					res_sample_q <= '0;
					res_snd_q    <= 1'b0;
				end else if (seg_q == SEG_SUS) begin
					e_q <= sus;
				end
			end
			S_ENV: begin
				case (seg_q)
					SEG_ATT: e_q <= (div_rsp.quo > FULL_SCALE) ? FULL_SCALE : div_rsp.quo;
					SEG_DEC: e_q <= (dec_lvl < sus) ? sus : dec_lvl;
					default: e_q <= div_rsp.quo;
				endcase
			end
			S_EG: prod_q <= mul_p;
			S_EW: prod_q <= mul_p;
			S_RND: begin
				res_sample_q <= sat;
				res_snd_q    <= 1'b1;
			end
			S_OUT: begin
				if (out_load) begin
					out_sample_q <= res_sample_q;
					out_snd_q    <= res_snd_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_sample_q;
	assign m_tuser[0] = out_snd_q;

`ifndef ASSERT_OFF
	// A silent tick always carries a zero sample
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 16'd0)
		else $error("silent result with nonzero sample");

	// A tick transfer starts the sequencer, which then holds off the next tick
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// The divider only reports while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider done outside divide state");
`endif

endmodule
